/* rtl/core/gapk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Growing atlas packer package
// Status codes and the transfer payload types shared by the packer files.
// ----------------------------------------------------------------------------
package gapk_pkg;

	localparam int unsigned IN_SIDE_W = 12;
	localparam int unsigned OUT_POS_W = 16;
	localparam int unsigned OUT_POW_W = 17;

	localparam logic [1:0] STATUS_PLACED   = 2'd0;
	localparam logic [1:0] STATUS_ZERO     = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic                 first_of_set;
		logic [IN_SIDE_W-1:0] rect_w;
		logic [IN_SIDE_W-1:0] rect_h;
	} rect_in_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] pos_x;
		logic [OUT_POS_W-1:0] pos_y;
		logic [OUT_POS_W-1:0] atlas_w;
		logic [OUT_POS_W-1:0] atlas_h;
		logic [OUT_POW_W-1:0] atlas_w_pow2;
		logic [OUT_POW_W-1:0] atlas_h_pow2;
		logic [1:0]           status;
	} place_out_t;

endpackage
`default_nettype wire

/* rtl/core/gapk_rect_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle channel
// Valid/ready channel carrying one rectangle per transfer.
// ----------------------------------------------------------------------------
interface gapk_rect_if;
	import gapk_pkg::*;
	logic     valid;
	logic     ready;
	rect_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/gapk_place_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Placement channel
// Valid/ready channel carrying one placement result per transfer.
// ----------------------------------------------------------------------------
interface gapk_place_if;
	import gapk_pkg::*;
	logic       valid;
	logic       ready;
	place_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/growing_atlas_rectangle_packer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Growing atlas rectangle packer
// Guillotine first-fit packer with a free-slot memory that grows the atlas.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  rect_in   sink       first_of_set, rect_w, rect_h
//  place_out source     pos_x, pos_y, atlas_w, atlas_h, pow2 sizes, status
//
// A rectangle first scans the free slots in order up to the matching one
// for the first-fit test, then moves each later slot down one entry for the
// ordered removal, and last writes the remainder slots. The single-port
// free-slot memory with its registered read sets the pace of each step.
// Reset clears the counters and atlas size; the memory needs no clearing.
// A new rectangle is taken while the previous result waits in the output
// register, but the result is only loaded once that register is free.
// ----------------------------------------------------------------------------
module growing_atlas_rectangle_packer_core
	import gapk_pkg::*;
#(
	parameter int unsigned MAX_SLOTS  = 256,
	parameter int unsigned SIDE_BITS  = 12,
	parameter int unsigned ATLAS_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	gapk_rect_if.sink    rect_in,
	gapk_place_if.source place_out
);

	localparam int unsigned IW = $clog2(MAX_SLOTS);
	localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
	localparam int unsigned AW = ATLAS_BITS;
	localparam int unsigned SW = 4 * AW;
	localparam int unsigned XW = (IN_SIDE_W > AW) ? IN_SIDE_W : AW;
	localparam logic [CW-1:0] CMAX = CW'(MAX_SLOTS);
	localparam logic [XW-1:0] SIDE_MASK = XW'((1 << SIDE_BITS) - 1);
	localparam logic [XW-1:0] ATLAS_TOP = XW'((1 << AW) - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CHK   = 3'd2;
	localparam logic [2:0] ST_MVRD  = 3'd3;
	localparam logic [2:0] ST_MVWR  = 3'd4;
	localparam logic [2:0] ST_PUSH  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	typedef struct packed {
		logic [AW-1:0] x;
		logic [AW-1:0] y;
		logic [AW-1:0] w;
		logic [AW-1:0] h;
	} slot_t;

	// Free-slot memory, single port, registered read.
	slot_t          mem [MAX_SLOTS];
	slot_t          rd_q;
	logic           mem_we;
	logic [IW-1:0]  mem_addr;
	slot_t          mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		rd_q <= mem[mem_addr];
	end

	logic [2:0]    state_q;
	logic [CW-1:0] count_q, idx_q;
	logic [AW-1:0] aw_q, ah_q;
	logic [AW-1:0] rw_q, rh_q;
	slot_t         hrem_q, wrem_q;
	logic          hpend_q, wpend_q;
	logic [AW-1:0] px_q, py_q;
	logic [1:0]    stat_q;
	logic          ovalid_q;
	place_out_t    odata_q;

	// Masked rectangle sides, held wide enough to spot a side that no atlas
	// can hold; such a rectangle ends in an overflow unless a side is zero.
	logic [XW-1:0] side_w, side_h;
	logic [AW-1:0] in_w, in_h;
	logic          side_big;
	assign side_w   = XW'(rect_in.data.rect_w) & SIDE_MASK;
	assign side_h   = XW'(rect_in.data.rect_h) & SIDE_MASK;
	assign in_w     = side_w[AW-1:0];
	assign in_h     = side_h[AW-1:0];
	assign side_big = (side_w > ATLAS_TOP) || (side_h > ATLAS_TOP);

	assign rect_in.ready = (state_q == ST_IDLE);

	// Fit test on the slot that was just read.
	logic fits;
	assign fits = (rd_q.w >= rw_q) && (rd_q.h >= rh_q);

	// Growth slot when no free slot holds the rectangle.
	logic          grow_y;
	slot_t         g;
	logic [AW:0]   nw_ext, nh_ext;
	assign grow_y = aw_q > ah_q;
	always_comb begin
		if (grow_y) begin
			g      = '{x: '0, y: ah_q, w: aw_q, h: rh_q};
			nw_ext = {1'b0, aw_q};
			nh_ext = {1'b0, ah_q} + {1'b0, rh_q};
		end else begin
			g      = '{x: aw_q, y: '0, w: rw_q, h: ah_q};
			nw_ext = {1'b0, aw_q} + {1'b0, rw_q};
			nh_ext = {1'b0, ah_q};
		end
	end

	// Remainders of a candidate slot s.
	function automatic logic [1:0] rem_cnt(slot_t s, logic [AW-1:0] w, logic [AW-1:0] h);
		rem_cnt = {1'b0, s.w > w} + {1'b0, s.h > h};
	endfunction

	logic [1:0]  frem, grem;
	logic [CW:0] fneed, gneed;
	assign frem  = rem_cnt(rd_q, rw_q, rh_q);
	assign grem  = rem_cnt(g, rw_q, rh_q);
	assign fneed = {1'b0, count_q} - 1'b1 + (CW+1)'(frem);
	assign gneed = {1'b0, count_q} + (CW+1)'(grem);

	// Power-of-two rounding: a one-hot above the leading one of v-1.
	function automatic logic [AW:0] pow2(logic [AW-1:0] v);
		logic [AW-1:0] m;
		m = v - 1'b1;
		for (int i = 1; i < AW; i = i * 2)
			m = m | (m >> i);
		pow2 = (v == '0) ? '0 : ({1'b0, m} + 1'b1);
	endfunction

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			aw_q     <= '0;
			ah_q     <= '0;
			idx_q    <= '0;
			hpend_q  <= 1'b0;
			wpend_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!ovalid_q || place_out.ready))
				ovalid_q <= 1'b1;
			else if (place_out.valid && place_out.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (rect_in.valid) begin
						rw_q    <= in_w;
						rh_q    <= in_h;
						px_q    <= '0;
						py_q    <= '0;
						idx_q   <= '0;
						hpend_q <= 1'b0;
						wpend_q <= 1'b0;
						if (side_w == '0 || side_h == '0) begin
							stat_q  <= STATUS_ZERO;
							state_q <= ST_DONE;
						end else if (side_big) begin
							stat_q  <= STATUS_OVERFLOW;
							state_q <= ST_DONE;
						end else if (rect_in.data.first_of_set || aw_q == '0 ||
							ah_q == '0) begin
							stat_q  <= STATUS_PLACED;
							aw_q    <= in_w;
							ah_q    <= in_h;
							count_q <= '0;
							state_q <= ST_DONE;
						end else begin
							stat_q  <= STATUS_PLACED;
							state_q <= (count_q == '0) ? ST_CHK : ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (idx_q < count_q && fits) begin
						if (fneed > {1'b0, CMAX}) begin
							stat_q  <= STATUS_OVERFLOW;
							state_q <= ST_DONE;
						end else begin
							px_q    <= rd_q.x;
							py_q    <= rd_q.y;
							hrem_q  <= '{x: rd_q.x, y: rd_q.y + rh_q,
								w: (rd_q.w > rw_q) ? rw_q : rd_q.w, h: rd_q.h - rh_q};
							wrem_q  <= '{x: rd_q.x + rw_q, y: rd_q.y,
								w: rd_q.w - rw_q, h: rd_q.h};
							hpend_q <= rd_q.h > rh_q;
							wpend_q <= rd_q.w > rw_q;
							state_q <= ST_MVRD;
						end
					end else if (idx_q + 1'b1 < count_q) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end else begin
						// No slot holds it: grow the atlas.
						if (g.w < rw_q || g.h < rh_q || nw_ext[AW] || nh_ext[AW] ||
							gneed > {1'b0, CMAX}) begin
							stat_q  <= STATUS_OVERFLOW;
							state_q <= ST_DONE;
						end else begin
							aw_q    <= nw_ext[AW-1:0];
							ah_q    <= nh_ext[AW-1:0];
							px_q    <= g.x;
							py_q    <= g.y;
							hrem_q  <= '{x: g.x, y: g.y + rh_q,
								w: (g.w > rw_q) ? rw_q : g.w, h: g.h - rh_q};
							wrem_q  <= '{x: g.x + rw_q, y: g.y, w: g.w - rw_q, h: g.h};
							hpend_q <= g.h > rh_q;
							wpend_q <= g.w > rw_q;
							idx_q   <= count_q;
							state_q <= ST_PUSH;
						end
					end
				end
				// Ordered removal: read entry idx+1, then write it to idx.
				ST_MVRD: begin
					if (idx_q + 1'b1 < count_q)
						state_q <= ST_MVWR;
					else begin
						count_q <= count_q - 1'b1;
						idx_q   <= count_q - 1'b1;
						state_q <= ST_PUSH;
					end
				end
				ST_MVWR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_MVRD;
				end
				ST_PUSH: begin
					if (hpend_q) begin
						hpend_q <= 1'b0;
						idx_q   <= idx_q + 1'b1;
						count_q <= count_q + 1'b1;
					end else if (wpend_q) begin
						wpend_q <= 1'b0;
						idx_q   <= idx_q + 1'b1;
						count_q <= count_q + 1'b1;
					end else
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!ovalid_q || place_out.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Memory port steering.
	logic [CW-1:0] rd_idx;
	always_comb begin
		mem_we  = 1'b0;
		mem_wd  = hpend_q ? hrem_q : wrem_q;
		rd_idx  = idx_q;
		priority case (state_q)
			ST_MVRD: rd_idx = idx_q + 1'b1;
			ST_MVWR: begin
				mem_we = 1'b1;
				mem_wd = rd_q;
			end
			ST_PUSH: mem_we = hpend_q || wpend_q;
			ST_IDLE: rd_idx = '0;
			default: rd_idx = idx_q;
		endcase
		mem_addr = rd_idx[IW-1:0];
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!ovalid_q || place_out.ready)) begin
			odata_q.pos_x        <= OUT_POS_W'(px_q);
			odata_q.pos_y        <= OUT_POS_W'(py_q);
			odata_q.atlas_w      <= OUT_POS_W'(aw_q);
			odata_q.atlas_h      <= OUT_POS_W'(ah_q);
			odata_q.atlas_w_pow2 <= OUT_POW_W'(pow2(aw_q));
			odata_q.atlas_h_pow2 <= OUT_POW_W'(pow2(ah_q));
			odata_q.status       <= stat_q;
		end
	end

	assign place_out.valid = ovalid_q;
	assign place_out.data  = odata_q;

	// Checks.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CMAX) else $error("free slot count above table size");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rect_in.ready == (state_q == ST_IDLE)) else $error("ready outside idle");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !ovalid_q) |=> ovalid_q)
		else $error("result not loaded");
	a_zero_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && stat_q == STATUS_ZERO) |-> (rw_q == '0 || rh_q == '0))
		else $error("zero status without zero side");

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Growing atlas packer testbench
// Drives rectangles into the packer with random gaps and checks each placement
// against a first-fit guillotine packer model held in a scoreboard class.
// ----------------------------------------------------------------------------
module tb;
	import gapk_pkg::*;

	localparam int unsigned SLOT_CAP  = 256;
	localparam int unsigned ATLAS_TOP = 65535;

	typedef struct {
		int unsigned x;
		int unsigned y;
		int unsigned w;
		int unsigned h;
	} slot_t;

	// Packer model and queue of pending placements.
	class packer_board;
		slot_t       slots[$];
		int unsigned aw;
		int unsigned ah;
		place_out_t  pending[$];
		int unsigned errors;
		int unsigned placed_cnt;
		int unsigned overflow_cnt;
		int unsigned grow_cnt;

		function int unsigned pow2_up(int unsigned v);
			int unsigned p;
			p = 1;
			if (v == 0)
				return 0;
			while (p < v)
				p = p << 1;
			return p;
		endfunction

		function int unsigned leftovers(slot_t s, int unsigned rw, int unsigned rh);
			return (s.w > rw ? 1 : 0) + (s.h > rh ? 1 : 0);
		endfunction

		// Height remainder first, then width remainder.
		function void split(slot_t s, int unsigned rw, int unsigned rh);
			slot_t n;
			if (s.h > rh) begin
				n.x = s.x; n.y = s.y + rh; n.w = (s.w > rw) ? rw : s.w; n.h = s.h - rh;
				slots.insert(slots.size(), n);
			end
			if (s.w > rw) begin
				n.x = s.x + rw; n.y = s.y; n.w = s.w - rw; n.h = s.h;
				slots.insert(slots.size(), n);
			end
		endfunction

		function void note_rect(rect_in_t r);
			place_out_t e;
			int unsigned rw, rh, px, py, nw, nh, found;
			logic [1:0] st;
			slot_t s, g;
			rw = r.rect_w; rh = r.rect_h; px = 0; py = 0; st = STATUS_PLACED;
			if (rw == 0 || rh == 0) begin
				st = STATUS_ZERO;
			end else if (r.first_of_set || aw == 0 || ah == 0) begin
				aw = rw; ah = rh;
				slots.delete();
			end else begin
				found = slots.size();
				foreach (slots[i]) begin
					if (found == slots.size() && slots[i].w >= rw && slots[i].h >= rh)
						found = i;
				end
				if (found < slots.size()) begin
					s = slots[found];
					if (slots.size() - 1 + leftovers(s, rw, rh) > SLOT_CAP) begin
						st = STATUS_OVERFLOW;
					end else begin
						slots.delete(found);
						split(s, rw, rh);
						px = s.x; py = s.y;
					end
				end else begin
					nw = aw; nh = ah;
					if (aw > ah) begin
						g.x = 0; g.y = ah; g.w = aw; g.h = rh; nh = ah + rh;
					end else begin
						g.x = aw; g.y = 0; g.w = rw; g.h = ah; nw = aw + rw;
					end
					if (g.w < rw || g.h < rh || nw > ATLAS_TOP || nh > ATLAS_TOP ||
							slots.size() + leftovers(g, rw, rh) > SLOT_CAP) begin
						st = STATUS_OVERFLOW;
					end else begin
						aw = nw; ah = nh;
						split(g, rw, rh);
						px = g.x; py = g.y;
						grow_cnt++;
					end
				end
			end
			if (st == STATUS_PLACED)
				placed_cnt++;
			if (st == STATUS_OVERFLOW)
				overflow_cnt++;
			e.pos_x = OUT_POS_W'(px); e.pos_y = OUT_POS_W'(py);
			e.atlas_w = OUT_POS_W'(aw); e.atlas_h = OUT_POS_W'(ah);
			e.atlas_w_pow2 = OUT_POW_W'(pow2_up(aw));
			e.atlas_h_pow2 = OUT_POW_W'(pow2_up(ah));
			e.status = st;
			pending.insert(pending.size(), e);
		endfunction

		function void check_place(place_out_t a);
			place_out_t e;
			if (pending.size() == 0) begin
				$error("unexpected placement %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.pos_x !== e.pos_x) begin
				$error("pos_x exp %0d got %0d", e.pos_x, a.pos_x); errors++;
			end
			if (a.pos_y !== e.pos_y) begin
				$error("pos_y exp %0d got %0d", e.pos_y, a.pos_y); errors++;
			end
			if (a.atlas_w !== e.atlas_w) begin
				$error("atlas_w exp %0d got %0d", e.atlas_w, a.atlas_w); errors++;
			end
			if (a.atlas_h !== e.atlas_h) begin
				$error("atlas_h exp %0d got %0d", e.atlas_h, a.atlas_h); errors++;
			end
			if (a.atlas_w_pow2 !== e.atlas_w_pow2) begin
				$error("atlas_w_pow2 exp %0d got %0d", e.atlas_w_pow2, a.atlas_w_pow2);
				errors++;
			end
			if (a.atlas_h_pow2 !== e.atlas_h_pow2) begin
				$error("atlas_h_pow2 exp %0d got %0d", e.atlas_h_pow2, a.atlas_h_pow2);
				errors++;
			end
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	gapk_rect_if  rect_ch ();
	gapk_place_if place_ch ();
	packer_board  board;
	bit           stim_done;
	int unsigned  sent;

	growing_atlas_rectangle_packer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.rect_in   (rect_ch.sink),
		.place_out (place_ch.source)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		rect_ch.valid  = 1'b0;
		rect_ch.data   = '0;
		place_ch.ready = 1'b0;
		arst_n         = 1'b0;
	end

	// Watch both channels at the rising edge.
	always @(posedge clk) begin
		if (arst_n && rect_ch.valid && rect_ch.ready)
			board.note_rect(rect_ch.data);
		if (arst_n && place_ch.valid && place_ch.ready)
			board.check_place(place_ch.data);
	end

	// Result side stalls at random, with calm stretches.
	initial begin : sink_proc
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				place_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			place_ch.ready <= 1'b1;
			do @(posedge clk); while (!place_ch.valid);
		end
	end

	// One rectangle transfer, preceded by a random gap unless calm is set.
	task automatic send_rect(bit first, int unsigned w, int unsigned h, bit calm);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			rect_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rect_ch.data  <= {first, w[11:0], h[11:0]};
		rect_ch.valid <= 1'b1;
		do @(posedge clk); while (!rect_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	// A sorted set with random sides up to the given limit top.
	task automatic send_set(int unsigned n, int unsigned top, bit calm);
		int unsigned sides[$];
		int unsigned a, b;
		for (int i = 0; i < n; i++)
			sides.insert(sides.size(), $urandom_range(1, top));
		sides.rsort();
		foreach (sides[i]) begin
			a = sides[i];
			b = $urandom_range(1, a);
			if ($urandom_range(0, 1))
				send_rect(i == 0, a, b, calm);
			else
				send_rect(i == 0, b, a, calm);
		end
	endtask

	initial begin : stim_proc
		int unsigned r;
		board = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: first rectangle without the flag, zero sizes, extremes.
		send_rect(0, 10, 6, 0);
		send_rect(1, 0, 5, 0);
		send_rect(1, 5, 0, 0);
		send_rect(0, 4, 3, 0);
		send_rect(0, 6, 6, 0);
		send_rect(0, 10, 10, 0);
		send_rect(1, 4095, 4095, 0);
		send_rect(0, 4095, 4095, 0);
		send_rect(0, 4095, 4095, 0);
		send_rect(0, 4095, 4095, 0);
		send_rect(0, 4095, 4095, 0);
		send_rect(0, 2730, 1365, 0);
		send_rect(1, 1, 1, 0);
		send_rect(0, 2, 2, 0);
		send_rect(0, 1, 1, 0);
		send_rect(1, 2048, 1, 0);
		send_rect(0, 2048, 2048, 0);
		// Atlas growth with a run of large rectangles.
		send_rect(1, 4095, 2048, 0);
		for (int i = 0; i < 6; i++)
			send_rect(0, 4095, 4095, 1);

		// Hold off until every placement is back.
		rect_ch.valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);

		// Many small rectangles to fill the free table.
		send_rect(1, 64, 64, 0);
		for (int i = 0; i < 300; i++)
			send_rect(0, $urandom_range(1, 2), $urandom_range(1, 2), i > 150);

		// Random sorted sets plus some noise.
		while (sent < 1700) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				send_rect(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
					$urandom_range(0, 4095), 0);
			else if (r == 1)
				send_set($urandom_range(2, 8), 4095, 1'($urandom_range(0, 1)));
			else
				send_set($urandom_range(3, 30), $urandom_range(4, 300), $urandom_range(0, 3) == 0);
		end
		rect_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin : end_proc
		wait (stim_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("Sent %0d rectangles: %0d placed, %0d grew the atlas, %0d overflowed.",
			sent, board.placed_cnt, board.grow_cnt, board.overflow_cnt);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : timeout_proc
		#20000000;
		$display("FAIL");
		$finish;
	end

endmodule
